// ===== hdl/lfsf_pkg.sv =====
// Package for the line-follow steering controller.
// Holds mode and command codes, fixed duties, register indexes and shared types.
// No dependencies.
package lfsf_pkg;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned LIM_W   = 12;
  localparam int unsigned DUTY_W  = 14;
  localparam int unsigned TIMER_W = 13;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned WDATA_W = 16;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 40;

  localparam logic [MODE_W-1:0] M_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] M_START   = 3'd1;
  localparam logic [MODE_W-1:0] M_FORWARD = 3'd2;
  localparam logic [MODE_W-1:0] M_MILD_L  = 3'd3;
  localparam logic [MODE_W-1:0] M_MILD_R  = 3'd4;
  localparam logic [MODE_W-1:0] M_SHARP_L = 3'd5;
  localparam logic [MODE_W-1:0] M_SHARP_R = 3'd6;
  localparam logic [MODE_W-1:0] M_STOP    = 3'd7;

  localparam logic [CMD_W-1:0] CMD_HOLD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRIVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  localparam logic [ADDR_W-1:0] REG_SHARP_ENTER = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MILD_ENTER  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_MILD_EXIT   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_SHARP_EXIT  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_START_LIMIT = 3'd4;
  localparam logic [ADDR_W-1:0] REG_CRUISE      = 3'd5;
  localparam logic [ADDR_W-1:0] REG_MILD_OUTER  = 3'd6;
  localparam logic [ADDR_W-1:0] REG_MILD_INNER  = 3'd7;

  localparam logic [DUTY_W-1:0]  SHARP_OUTER = 14'd1500;
  localparam logic [DUTY_W-1:0]  SHARP_INNER = 14'd500;
  localparam logic [TIMER_W:0]   START_STEP  = 14'd80;
  localparam logic [TIMER_W-1:0] TIMER_MAX   = 13'd8191;

  localparam logic [THR_W-1:0]  RST_SHARP_ENTER = 16'd8000;
  localparam logic [THR_W-1:0]  RST_MILD_ENTER  = 16'd4800;
  localparam logic [THR_W-1:0]  RST_MILD_EXIT   = 16'd800;
  localparam logic [THR_W-1:0]  RST_SHARP_EXIT  = 16'd6000;
  localparam logic [LIM_W-1:0]  RST_START_LIMIT = 12'd1500;
  localparam logic [DUTY_W-1:0] RST_CRUISE      = 14'd2500;
  localparam logic [DUTY_W-1:0] RST_MILD_OUTER  = 14'd1700;
  localparam logic [DUTY_W-1:0] RST_MILD_INNER  = 14'd1000;

  typedef struct packed {
    logic [THR_W-1:0]  sharp_enter;
    logic [THR_W-1:0]  mild_enter;
    logic [THR_W-1:0]  mild_exit;
    logic [THR_W-1:0]  sharp_exit;
    logic [LIM_W-1:0]  start_limit;
    logic [DUTY_W-1:0] cruise_duty;
    logic [DUTY_W-1:0] mild_outer_duty;
    logic [DUTY_W-1:0] mild_inner_duty;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic [CMD_W-1:0]  command;
  } result_t;

endpackage

// ===== hdl/lfsf_cfg.sv =====
// Configuration register file of the line-follow steering controller.
// Depends on lfsf_pkg.
module lfsf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lfsf_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [lfsf_pkg::WDATA_W-1:0] cfg_wdata,
  output lfsf_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sharp_enter     <= lfsf_pkg::RST_SHARP_ENTER;
      cfg.mild_enter      <= lfsf_pkg::RST_MILD_ENTER;
      cfg.mild_exit       <= lfsf_pkg::RST_MILD_EXIT;
      cfg.sharp_exit      <= lfsf_pkg::RST_SHARP_EXIT;
      cfg.start_limit     <= lfsf_pkg::RST_START_LIMIT;
      cfg.cruise_duty     <= lfsf_pkg::RST_CRUISE;
      cfg.mild_outer_duty <= lfsf_pkg::RST_MILD_OUTER;
      cfg.mild_inner_duty <= lfsf_pkg::RST_MILD_INNER;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lfsf_pkg::REG_SHARP_ENTER: cfg.sharp_enter <= cfg_wdata;
        lfsf_pkg::REG_MILD_ENTER:  cfg.mild_enter  <= cfg_wdata;
        lfsf_pkg::REG_MILD_EXIT:   cfg.mild_exit   <= cfg_wdata;
        lfsf_pkg::REG_SHARP_EXIT:  cfg.sharp_exit  <= cfg_wdata;
        lfsf_pkg::REG_START_LIMIT: cfg.start_limit <= cfg_wdata[lfsf_pkg::LIM_W-1:0];
        lfsf_pkg::REG_CRUISE:      cfg.cruise_duty <= cfg_wdata[lfsf_pkg::DUTY_W-1:0];
        lfsf_pkg::REG_MILD_OUTER:  cfg.mild_outer_duty <= cfg_wdata[lfsf_pkg::DUTY_W-1:0];
        lfsf_pkg::REG_MILD_INNER:  cfg.mild_inner_duty <= cfg_wdata[lfsf_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/lfsf_step.sv =====
// Next-state and command logic for one control tick.
// Depends on lfsf_pkg.
module lfsf_step (
  input  lfsf_pkg::cfg_t                     cfg,
  input  logic [lfsf_pkg::MODE_W-1:0]        mode,
  input  logic [lfsf_pkg::TIMER_W-1:0]       timer,
  input  logic signed [lfsf_pkg::POS_W-1:0]  line_position,
  input  logic                               bumped,
  input  logic                               button_pressed,
  output logic [lfsf_pkg::MODE_W-1:0]        mode_next,
  output logic [lfsf_pkg::TIMER_W-1:0]       timer_next,
  output lfsf_pkg::result_t                  res
);

  logic signed [lfsf_pkg::POS_W:0] pos;
  logic signed [lfsf_pkg::POS_W:0] se, me, mx, sx;
  logic [lfsf_pkg::TIMER_W:0]      tsum;
  logic [lfsf_pkg::TIMER_W-1:0]    tsat;

  assign pos = {line_position[lfsf_pkg::POS_W-1], line_position};
  assign se  = signed'({2'b00, cfg.sharp_enter});
  assign me  = signed'({2'b00, cfg.mild_enter});
  assign mx  = signed'({2'b00, cfg.mild_exit});
  assign sx  = signed'({2'b00, cfg.sharp_exit});

  assign tsum = {1'b0, timer} + lfsf_pkg::START_STEP;
  assign tsat = tsum[lfsf_pkg::TIMER_W] ? lfsf_pkg::TIMER_MAX : tsum[lfsf_pkg::TIMER_W-1:0];

  always_comb begin
    mode_next      = mode;
    timer_next     = timer;
    res.command    = lfsf_pkg::CMD_HOLD;
    res.left_duty  = '0;
    res.right_duty = '0;
    if (bumped) begin
      mode_next   = lfsf_pkg::M_STOP;
      res.command = lfsf_pkg::CMD_STOP;
    end else begin
      unique case (mode)
        lfsf_pkg::M_IDLE: begin
          if (button_pressed) begin
            mode_next  = lfsf_pkg::M_START;
            timer_next = '0;
          end
        end
        lfsf_pkg::M_START: begin
          res.command    = lfsf_pkg::CMD_DRIVE;
          res.left_duty  = cfg.cruise_duty;
          res.right_duty = cfg.cruise_duty;
          timer_next     = tsat;
          if (tsat >= {1'b0, cfg.start_limit}) begin
            mode_next = lfsf_pkg::M_FORWARD;
          end
        end
        lfsf_pkg::M_FORWARD: begin
          priority if (pos > se) begin
            mode_next = lfsf_pkg::M_SHARP_L;
          end else if (pos > me) begin
            mode_next = lfsf_pkg::M_MILD_L;
          end else if (pos < -se) begin
            mode_next = lfsf_pkg::M_SHARP_R;
          end else if (pos < -me) begin
            mode_next = lfsf_pkg::M_MILD_R;
          end else begin
            res.command    = lfsf_pkg::CMD_DRIVE;
            res.left_duty  = cfg.cruise_duty;
            res.right_duty = cfg.cruise_duty;
          end
        end
        lfsf_pkg::M_MILD_L: begin
          res.command    = lfsf_pkg::CMD_DRIVE;
          res.left_duty  = cfg.mild_outer_duty;
          res.right_duty = cfg.mild_inner_duty;
          if (pos <= mx) begin
            mode_next = lfsf_pkg::M_FORWARD;
          end else if (pos > se) begin
            mode_next = lfsf_pkg::M_SHARP_L;
          end
        end
        lfsf_pkg::M_MILD_R: begin
          res.command    = lfsf_pkg::CMD_DRIVE;
          res.left_duty  = cfg.mild_inner_duty;
          res.right_duty = cfg.mild_outer_duty;
          if (pos >= -mx) begin
            mode_next = lfsf_pkg::M_FORWARD;
          end else if (pos < -se) begin
            mode_next = lfsf_pkg::M_SHARP_R;
          end
        end
        lfsf_pkg::M_SHARP_L: begin
          res.command    = lfsf_pkg::CMD_DRIVE;
          res.left_duty  = lfsf_pkg::SHARP_OUTER;
          res.right_duty = lfsf_pkg::SHARP_INNER;
          if (pos <= sx) begin
            mode_next = lfsf_pkg::M_FORWARD;
          end
        end
        lfsf_pkg::M_SHARP_R: begin
          res.command    = lfsf_pkg::CMD_DRIVE;
          res.left_duty  = lfsf_pkg::SHARP_INNER;
          res.right_duty = lfsf_pkg::SHARP_OUTER;
          if (pos >= -sx) begin
            mode_next = lfsf_pkg::M_FORWARD;
          end
        end
        lfsf_pkg::M_STOP: begin
          mode_next   = lfsf_pkg::M_STOP;
          res.command = lfsf_pkg::CMD_STOP;
        end
        default: begin
          mode_next   = lfsf_pkg::M_STOP;
          res.command = lfsf_pkg::CMD_STOP;
        end
      endcase
    end
    res.mode = mode_next;
  end

endmodule

// ===== hdl/line_follow_steering_fsm.sv =====
// Top level of the line-follow steering controller: mode and timer state,
// output word register and stream handshakes. Depends on lfsf_pkg, lfsf_cfg, lfsf_step.
// The result word of an accepted input word is registered and shown on m_tdata in the next cycle.
// Throughput: one word per cycle; a word is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset (rst, synchronous): registers to defaults, mode idle, timer zero, output empty.
module line_follow_steering_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lfsf_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [lfsf_pkg::WDATA_W-1:0] cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // line_position[16:0], bumped[17], button_pressed[18], zero[23:19]
  input  logic [lfsf_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // command[1:0], left_duty[15:2], right_duty[29:16], mode[32:30], zero[39:33]
  output logic [lfsf_pkg::OUT_W-1:0]   m_tdata
);

  lfsf_pkg::cfg_t                    cfg;
  logic [lfsf_pkg::MODE_W-1:0]       mode;
  logic [lfsf_pkg::MODE_W-1:0]       mode_next;
  logic [lfsf_pkg::TIMER_W-1:0]      timer;
  logic [lfsf_pkg::TIMER_W-1:0]      timer_next;
  lfsf_pkg::result_t                 res;
  lfsf_pkg::result_t                 out_word;
  logic                              accept;

  lfsf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfsf_step u_step (
    .cfg            (cfg),
    .mode           (mode),
    .timer          (timer),
    .line_position  (signed'(s_tdata[lfsf_pkg::POS_W-1:0])),
    .bumped         (s_tdata[lfsf_pkg::POS_W]),
    .button_pressed (s_tdata[lfsf_pkg::POS_W+1]),
    .mode_next      (mode_next),
    .timer_next     (timer_next),
    .res            (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(lfsf_pkg::OUT_W - $bits(lfsf_pkg::result_t)){1'b0}}, out_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= lfsf_pkg::M_IDLE;
      timer    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        mode     <= mode_next;
        timer    <= timer_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= res;
    end
  end

  a_bump_stops: assert property (@(posedge clk) disable iff (rst)
    accept && s_tdata[lfsf_pkg::POS_W] |=> m_tvalid && out_word.mode == lfsf_pkg::M_STOP
      && out_word.command == lfsf_pkg::CMD_STOP)
    else $error("bump did not force stop");

  a_stop_absorbs: assert property (@(posedge clk) disable iff (rst)
    mode == lfsf_pkg::M_STOP |=> mode == lfsf_pkg::M_STOP)
    else $error("left stop mode");

  a_idle_duties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_word.command != lfsf_pkg::CMD_DRIVE |->
      out_word.left_duty == '0 && out_word.right_duty == '0)
    else $error("nonzero duty without drive");

  a_mode_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_word.mode == mode)
    else $error("result mode differs from state");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept && !$past(rst) |=> $stable(mode) && $stable(timer))
    else $error("state changed without input");

endmodule
